FILE: sv/bsm_pkg.sv
// ---------------------------------------------------------------------------
// bsm_pkg
// Shared types, codes and constants for the bank switch mapper core.
// ---------------------------------------------------------------------------
package bsm_pkg;

  localparam int WORK_RAM_BYTES_DEF = 4096;

  // item kinds (in_tuser)
  localparam logic [1:0] ACT_REG_WR = 2'd0;
  localparam logic [1:0] ACT_LOW_WR = 2'd1;
  localparam logic [1:0] ACT_LOW_RD = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  // mapper register decode: {addr[15:13], addr[0]}
  localparam logic [3:0] MREG_BANK_SEL    = 4'b1000;
  localparam logic [3:0] MREG_BANK_DATA   = 4'b1001;
  localparam logic [3:0] MREG_MIRROR      = 4'b1010;
  localparam logic [3:0] MREG_IRQ_LATCH   = 4'b1100;
  localparam logic [3:0] MREG_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] MREG_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] MREG_IRQ_ENABLE  = 4'b1111;

  // bank data target, from bank_select[2:0]
  localparam logic [2:0] BSEL_CHR_01 = 3'd0;
  localparam logic [2:0] BSEL_CHR_23 = 3'd1;
  localparam logic [2:0] BSEL_CHR_4  = 3'd2;
  localparam logic [2:0] BSEL_CHR_5  = 3'd3;
  localparam logic [2:0] BSEL_CHR_6  = 3'd4;
  localparam logic [2:0] BSEL_CHR_7  = 3'd5;
  localparam logic [2:0] BSEL_PRG_0  = 3'd6;
  localparam logic [2:0] BSEL_PRG_1  = 3'd7;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd1;
  localparam logic [1:0] CFG_CHR_ROM     = 2'd2;

  localparam logic [8:0]  PRG_COUNT_RST = 9'd32;
  localparam logic [15:0] LOW_BASE      = 16'h5000;
  localparam logic [15:0] LOW_LAST      = 16'h5FFF;
  localparam logic [7:0]  PRG_LIMIT     = 8'h50;
  localparam logic [7:0]  PRG_MASK      = 8'h4F;
  localparam logic [7:0]  EVEN_MASK     = 8'hFE;
  localparam logic [8:0]  LAST_LINE     = 9'd239;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        display_on;
    logic [1:0]  action;
  } bsm_item_t;

  typedef struct packed {
    logic [8:0] prg_bank_count;
    logic       four_screen;
    logic       chr_rom_present;
  } bsm_cfg_t;

  typedef struct packed {
    logic [31:0] prg_map;
    logic [63:0] chr_map;
    logic        chr_map_valid;
    logic        mirror_horizontal;
    logic        irq_line;
  } bsm_map_t;

  function automatic logic [7:0] clamp_prg(input logic [7:0] v);
    clamp_prg = (v >= PRG_LIMIT) ? (v & PRG_MASK) : v;
  endfunction

endpackage

FILE: sv/bank_switch_mapper_with_scanline_irq_core.sv
// ---------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq_core
// Cartridge bank mapper with work RAM and a scanline interrupt counter.
// ---------------------------------------------------------------------------
//
//  port group | dir  | carries
//  -----------+------+------------------------------------------------------
//  in_*       | in   | one bus access or scanline tick per item
//  out_*      | out  | read data, PRG/CHR maps, mirroring, IRQ line per item
//  cfg_*      | both | bank count, four-screen, CHR ROM present (APB)
//
//  One item per clock sustained while out_* is not stalled; an item passes
//  through the input register, then the result register, on its way to out_*.
//  After rst_n the work RAM is zero-filled, one byte a cycle: in_tready stays
//  low until all WORK_RAM_BYTES (4096) bytes are clear. Config writes are taken throughout.
//  A stalled out_* holds the result; the input register keeps taking items
//  until it too is full.
//
module bank_switch_mapper_with_scanline_irq_core #(
  parameter int WORK_RAM_BYTES = bsm_pkg::WORK_RAM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // addr[15:0], data[23:16], scanline[32:24],
                                   // display_on[33], zero pad
  input  logic [1:0]   in_tuser,   // action
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // read_data[7:0], prg_map[39:8], chr_map[103:40],
                                   // mirror_horizontal[104], irq_line[105], zero pad
  output logic         out_tuser,  // chr_map_valid
  // configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import bsm_pkg::*;

  localparam int AW = $clog2(WORK_RAM_BYTES);

  // configuration registers
  bsm_cfg_t cfg_r;
  logic     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_bank_count  <= PRG_COUNT_RST;
      cfg_r.four_screen     <= 1'b0;
      cfg_r.chr_rom_present <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        CFG_PRG_COUNT:   cfg_r.prg_bank_count  <= cfg_pwdata[8:0];
        CFG_FOUR_SCREEN: cfg_r.four_screen     <= cfg_pwdata[0];
        CFG_CHR_ROM:     cfg_r.chr_rom_present <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      CFG_PRG_COUNT:   cfg_prdata = {23'd0, cfg_r.prg_bank_count};
      CFG_FOUR_SCREEN: cfg_prdata = {31'd0, cfg_r.four_screen};
      CFG_CHR_ROM:     cfg_prdata = {31'd0, cfg_r.chr_rom_present};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // input side: unpack, range check, work RAM access at accept time so RAM
  // ops stay in item order and read data lands beside the input register
  bsm_item_t in_item;
  logic      in_accept, in_low, ram_ready;
  logic      s1_v_r, s1_low_r, s1_adv;
  bsm_item_t s1_item_r;
  logic [7:0] ram_rdata;

  assign in_item.addr       = in_tdata[15:0];
  assign in_item.data       = in_tdata[23:16];
  assign in_item.scanline   = in_tdata[32:24];
  assign in_item.display_on = in_tdata[33];
  assign in_item.action     = in_tuser;

  assign in_low    = (in_item.addr >= LOW_BASE) && (in_item.addr <= LOW_LAST);
  assign s1_adv    = s1_v_r & (~out_tvalid | out_tready);
  assign in_tready = ram_ready & (~s1_v_r | s1_adv);
  assign in_accept = in_tvalid & in_tready;

  bsm_wram #(
    .DEPTH(WORK_RAM_BYTES)
  ) u_wram (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (in_accept && in_item.action == ACT_LOW_WR && in_low),
    .rd_en (in_accept),
    .idx   (in_item.addr[AW-1:0]),  // window base has zero low bits
    .wdata (in_item.data),
    .rdata (ram_rdata),
    .ready (ram_ready)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
      s1_low_r  <= in_low;
    end
  end

  // mapper state commits when the item moves into the result register
  bsm_map_t map;

  bsm_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .map    (map)
  );

  // result register
  logic       out_v_r;
  bsm_map_t   out_map_r;
  logic [7:0] out_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_map_r <= map;
      out_rd_r  <= (s1_item_r.action == ACT_LOW_RD && s1_low_r) ? ram_rdata : 8'd0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_map_r.irq_line, out_map_r.mirror_horizontal,
                       out_map_r.chr_map, out_map_r.prg_map, out_rd_r};
  assign out_tuser  = out_map_r.chr_map_valid;

endmodule

FILE: sv/bsm_wram.sv
// ---------------------------------------------------------------------------
// bsm_wram
// Work RAM with a zero-fill sweep after reset; registered read data.
// ---------------------------------------------------------------------------
module bsm_wram #(
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] idx,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata,
  output logic                     ready
);
  localparam int AW = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_r;
  logic [AW-1:0] clr_idx_r;
  logic          clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == AW'(DEPTH - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= 8'd0;
    end else if (wr_en) begin
      mem[idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= mem[idx];
  end

  assign rdata = rdata_r;
  assign ready = ~clr_busy_r;

endmodule

FILE: sv/bsm_regs.sv
// ---------------------------------------------------------------------------
// bsm_regs
// Mapper register file and scanline IRQ counter; builds the bank maps
// from the state as it stands after the committing item.
// ---------------------------------------------------------------------------
module bsm_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  bsm_pkg::bsm_item_t item,
  input  bsm_pkg::bsm_cfg_t  cfg,
  output bsm_pkg::bsm_map_t  map
);
  import bsm_pkg::*;

  logic [7:0] bank_sel_r,   bank_sel_nxt;
  logic [7:0] chr_bank_r   [8];
  logic [7:0] chr_bank_nxt [8];
  logic [7:0] prg_lo_r     [2];
  logic [7:0] prg_lo_nxt   [2];
  logic       mirror_r,     mirror_nxt;
  logic [7:0] irq_cnt_r,    irq_cnt_nxt;
  logic [7:0] irq_reload_r, irq_reload_nxt;
  logic       irq_en_r,     irq_en_nxt;
  logic       irq_pend_r,   irq_pend_nxt;
  logic       irq_out_r,    irq_out_nxt;

  logic [7:0] even;
  logic [7:0] cnt_pre;
  logic [3:0] mreg;
  logic [7:0] fix2, fix3, s0, s2;

  assign even = item.data & EVEN_MASK;
  assign mreg = {item.addr[15:13], item.addr[0]};
  // line 0 takes an extra decrement on a nonzero count
  assign cnt_pre = (item.scanline == 9'd0 && irq_cnt_r != 8'd0) ? irq_cnt_r - 8'd1
                                                                : irq_cnt_r;

  always_comb begin
    bank_sel_nxt   = bank_sel_r;
    chr_bank_nxt   = chr_bank_r;
    prg_lo_nxt     = prg_lo_r;
    mirror_nxt     = mirror_r;
    irq_cnt_nxt    = irq_cnt_r;
    irq_reload_nxt = irq_reload_r;
    irq_en_nxt     = irq_en_r;
    irq_pend_nxt   = irq_pend_r;
    irq_out_nxt    = irq_out_r;
    if (commit && item.action == ACT_REG_WR) begin
      unique case (mreg)
        MREG_BANK_SEL: bank_sel_nxt = item.data;
        MREG_BANK_DATA: begin
          unique case (bank_sel_r[2:0])
            BSEL_CHR_01: begin
              chr_bank_nxt[0] = even;
              chr_bank_nxt[1] = even | 8'd1;
            end
            BSEL_CHR_23: begin
              chr_bank_nxt[2] = even;
              chr_bank_nxt[3] = even | 8'd1;
            end
            BSEL_CHR_4: chr_bank_nxt[4] = item.data;
            BSEL_CHR_5: chr_bank_nxt[5] = item.data;
            BSEL_CHR_6: chr_bank_nxt[6] = item.data;
            BSEL_CHR_7: chr_bank_nxt[7] = item.data;
            BSEL_PRG_0: prg_lo_nxt[0]   = clamp_prg(item.data);
            default: prg_lo_nxt[1] = clamp_prg(item.data);
          endcase
        end
        MREG_MIRROR: begin
          if (!cfg.four_screen) mirror_nxt = item.data[0];
        end
        MREG_IRQ_LATCH: begin
          irq_cnt_nxt  = item.data;
          irq_pend_nxt = 1'b0;
        end
        MREG_IRQ_RELOAD: begin
          irq_reload_nxt = item.data;
          irq_pend_nxt   = 1'b0;
        end
        MREG_IRQ_DISABLE: begin
          irq_en_nxt   = 1'b0;
          irq_pend_nxt = 1'b0;
          irq_out_nxt  = 1'b0;
        end
        MREG_IRQ_ENABLE: begin
          irq_en_nxt   = 1'b1;
          irq_pend_nxt = 1'b0;
        end
        default: ;
      endcase
    end else if (commit && item.action == ACT_TICK) begin
      if (item.scanline <= LAST_LINE && item.display_on && irq_en_r && !irq_pend_r) begin
        if (cnt_pre == 8'd0) begin
          irq_cnt_nxt  = irq_reload_r;
          irq_pend_nxt = 1'b1;
          irq_out_nxt  = 1'b1;
        end else begin
          irq_cnt_nxt = cnt_pre - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_sel_r   <= 8'd0;
      for (int i = 0; i < 8; i++) chr_bank_r[i] <= 8'(i);
      prg_lo_r[0]  <= 8'd0;
      prg_lo_r[1]  <= 8'd1;
      mirror_r     <= 1'b0;
      irq_cnt_r    <= 8'd0;
      irq_reload_r <= 8'd0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      irq_out_r    <= 1'b0;
    end else begin
      bank_sel_r   <= bank_sel_nxt;
      chr_bank_r   <= chr_bank_nxt;
      prg_lo_r     <= prg_lo_nxt;
      mirror_r     <= mirror_nxt;
      irq_cnt_r    <= irq_cnt_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_pend_r   <= irq_pend_nxt;
      irq_out_r    <= irq_out_nxt;
    end
  end

  // maps are built from the post-item state
  assign fix2 = cfg.prg_bank_count[7:0] - 8'd2;
  assign fix3 = cfg.prg_bank_count[7:0] - 8'd1;
  assign s0   = bank_sel_nxt[6] ? fix2 : prg_lo_nxt[0];
  assign s2   = bank_sel_nxt[6] ? prg_lo_nxt[0] : fix2;

  always_comb begin
    map.prg_map = {fix3, s2, prg_lo_nxt[1], s0};
    map.chr_map = '0;
    if (cfg.chr_rom_present) begin
      for (int i = 0; i < 8; i++) begin
        map.chr_map[8*i +: 8] = chr_bank_nxt[3'(i) ^ {bank_sel_nxt[7], 2'b00}];
      end
    end
    map.chr_map_valid     = cfg.chr_rom_present;
    map.mirror_horizontal = mirror_nxt;
    map.irq_line          = irq_out_nxt;
  end

endmodule
